// ----- src/gbef_pkg.sv -----
// Shared constants, opcodes and lane control type for the gyro rate filter.
package gbef_pkg;

  localparam int RAW_WIDTH  = 16;
  localparam int RATE_WIDTH = 32;
  localparam int NUM_AXES   = 3;

  localparam int ALPHA_W    = 17;
  localparam int ALPHA_FRAC = 16;
  localparam int GAIN_W     = 16;
  localparam int COUNT_W    = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 17;

  // raw * gain, gain zero-extended to a signed operand
  localparam int PROD_W = RAW_WIDTH + GAIN_W + 1;
  // bias subtraction headroom
  localparam int DIFF_W = ((PROD_W > RATE_WIDTH) ? PROD_W : RATE_WIDTH) + 1;
  // rate * weight products and their sum
  localparam int MUL_W  = RATE_WIDTH + ALPHA_W + 1;
  localparam int EMA_W  = MUL_W + 1;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(1) << ALPHA_FRAC;
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(58982);
  localparam logic [GAIN_W-1:0]  GAIN_RESET  = GAIN_W'(8960);
  localparam logic [COUNT_W-1:0] CALIB_RESET = COUNT_W'(40);
  localparam logic [COUNT_W-1:0] COUNT_MAX   = '1;

  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN  = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_CALIB = CFG_IDX_W'(2);

  typedef enum logic [1:0] {
    OP_SAMPLE = 2'd0,
    OP_RESET  = 2'd1,
    OP_UPDATE = 2'd2
  } op_t;

  typedef struct packed {
    logic load_raw;       // sample request accepted: scale raw, weight old filter
    logic sub;            // remove bias and saturate
    logic mul_new;        // weight new sample
    logic ema;            // sum, round, saturate
    logic commit_sample;  // write back filter (and bias mean)
    logic clear_filt;     // zero the filter
    logic take_bias;      // copy filter into bias
    logic mean_bias;      // bias tracks mean while uncalibrated
    logic first;          // first sample loads filter directly
    logic bias_on;        // subtract stored bias
  } lane_ctl_t;

endpackage

// ----- src/gyro_bias_calibrated_ema_filter_unit.sv -----
// Top level: three-axis gyro rate EMA filter with bias calibration.
// A sample request steps through scale, bias subtract, weight, sum, write back and report;
//   a command skips to write back and report. A new request is taken only once the last
//   one has been reported, and a stalled output holds the report step.
// A finished result waits in the output register while the next request is worked on.
// Reset (rst, synchronous): filters, biases, count and flag cleared; registers
//   return to alpha 0.9, gain 35.0, calibration length 40.
module gyro_bias_calibrated_ema_filter_unit import gbef_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  // configuration writes, always ready
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  // request channel
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic signed [RAW_WIDTH-1:0]  raw_x,
  input  logic signed [RAW_WIDTH-1:0]  raw_y,
  input  logic signed [RAW_WIDTH-1:0]  raw_z,
  // result channel
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [RATE_WIDTH-1:0] rate_x,
  output logic signed [RATE_WIDTH-1:0] rate_y,
  output logic signed [RATE_WIDTH-1:0] rate_z,
  output logic                         calibrated,
  output logic                         calib_done,
  output logic [COUNT_W-1:0]           samples_seen
);

  logic [ALPHA_W-1:0] alpha_weight;
  logic [GAIN_W-1:0]  scale_gain;
  logic [COUNT_W-1:0] calib_length;

  // weight above one is clamped; complement weights the old filter value
  logic [ALPHA_W-1:0] alpha_eff;
  logic [ALPHA_W-1:0] alpha_c;

  lane_ctl_t                    ctl;
  logic signed [RAW_WIDTH-1:0]  raw  [NUM_AXES];
  logic signed [RATE_WIDTH-1:0] filt [NUM_AXES];
  logic signed [RATE_WIDTH-1:0] rate [NUM_AXES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_weight <= ALPHA_RESET;
      scale_gain   <= GAIN_RESET;
      calib_length <= CALIB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ALPHA: alpha_weight <= cfg_wdata[ALPHA_W-1:0];
        CFG_GAIN:  scale_gain   <= cfg_wdata[GAIN_W-1:0];
        CFG_CALIB: calib_length <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    alpha_eff = (alpha_weight > ALPHA_ONE) ? ALPHA_ONE : alpha_weight;
    alpha_c   = ALPHA_ONE - alpha_eff;
  end

  assign raw[0] = raw_x;
  assign raw[1] = raw_y;
  assign raw[2] = raw_z;

  // one lane per axis, all driven by the same control word
  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    gbef_lane u_lane (
      .clk     (clk),
      .rst     (rst),
      .ctl     (ctl),
      .raw     (raw[i]),
      .gain    (scale_gain),
      .alpha   (alpha_eff),
      .alpha_c (alpha_c),
      .filt    (filt[i])
    );
  end

  // sequencer plus merge of lane state into the result register
  gbef_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .calib_len    (calib_length),
    .filt         (filt),
    .ctl          (ctl),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rate         (rate),
    .calibrated   (calibrated),
    .calib_done   (calib_done),
    .samples_seen (samples_seen)
  );

  assign rate_x = rate[0];
  assign rate_y = rate[1];
  assign rate_z = rate[2];

endmodule

// ----- src/gbef_lane.sv -----
// One axis of the filter datapath: scale, bias removal, EMA and per-axis state.
module gbef_lane import gbef_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  lane_ctl_t                    ctl,
  input  logic signed [RAW_WIDTH-1:0]  raw,
  input  logic [GAIN_W-1:0]            gain,
  input  logic [ALPHA_W-1:0]           alpha,
  input  logic [ALPHA_W-1:0]           alpha_c,
  output logic signed [RATE_WIDTH-1:0] filt
);

  localparam logic signed [RATE_WIDTH-1:0] RATE_MAX = {1'b0, {(RATE_WIDTH-1){1'b1}}};
  localparam logic signed [RATE_WIDTH-1:0] RATE_MIN = {1'b1, {(RATE_WIDTH-1){1'b0}}};
  localparam logic signed [EMA_W-1:0] ROUND_HALF = EMA_W'(1) << (ALPHA_FRAC - 1);

  logic signed [RATE_WIDTH-1:0] bias;
  logic signed [PROD_W-1:0]     prod;
  logic signed [MUL_W-1:0]      m_old;
  logic signed [MUL_W-1:0]      m_new;
  logic signed [RATE_WIDTH-1:0] v;
  logic signed [RATE_WIDTH-1:0] fnew;

  logic signed [DIFF_W-1:0]     diff;
  logic signed [RATE_WIDTH-1:0] v_next;
  logic signed [EMA_W-1:0]      acc;
  logic signed [EMA_W-1:0]      acc_sh;
  logic signed [RATE_WIDTH-1:0] ema_sat;
  logic signed [RATE_WIDTH:0]   bias_sum;
  logic signed [RATE_WIDTH-1:0] bias_mean;

  always_comb begin
    diff = DIFF_W'(prod) - (ctl.bias_on ? DIFF_W'(bias) : '0);
    if ((&diff[DIFF_W-1:RATE_WIDTH-1]) || !(|diff[DIFF_W-1:RATE_WIDTH-1])) begin
      v_next = diff[RATE_WIDTH-1:0];
    end else begin
      v_next = diff[DIFF_W-1] ? RATE_MIN : RATE_MAX;
    end

    acc    = EMA_W'(m_old) + EMA_W'(m_new) + ROUND_HALF;
    acc_sh = acc >>> ALPHA_FRAC;
    if ((&acc_sh[EMA_W-1:RATE_WIDTH-1]) || !(|acc_sh[EMA_W-1:RATE_WIDTH-1])) begin
      ema_sat = acc_sh[RATE_WIDTH-1:0];
    end else begin
      ema_sat = acc_sh[EMA_W-1] ? RATE_MIN : RATE_MAX;
    end

    // floor of the mean
    bias_sum  = (RATE_WIDTH+1)'(bias) + (RATE_WIDTH+1)'(fnew);
    bias_mean = bias_sum[RATE_WIDTH:1];
  end

  // datapath pipeline, one step per sequencer state
  always_ff @(posedge clk) begin
    if (ctl.load_raw) begin
      prod  <= raw * $signed({1'b0, gain});
      m_old <= filt * $signed({1'b0, alpha_c});
    end
    if (ctl.sub) begin
      v <= v_next;
    end
    if (ctl.mul_new) begin
      m_new <= v * $signed({1'b0, alpha});
    end
    if (ctl.ema) begin
      fnew <= ctl.first ? v : ema_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      filt <= '0;
      bias <= '0;
    end else begin
      priority if (ctl.commit_sample) begin
        if (ctl.mean_bias) begin
          bias <= bias_mean;
        end
        filt <= ctl.clear_filt ? '0 : fnew;
      end else if (ctl.take_bias) begin
        bias <= filt;
        filt <= '0;
      end else if (ctl.clear_filt) begin
        filt <= '0;
      end else begin
        // no write-back this cycle
        filt <= filt;
      end
    end
  end

endmodule

// ----- src/gbef_ctrl.sv -----
// Sequencer, calibration counter and result merge for the three lanes.
module gbef_ctrl import gbef_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic [COUNT_W-1:0]           calib_len,
  input  logic signed [RATE_WIDTH-1:0] filt [NUM_AXES],
  output lane_ctl_t                    ctl,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [RATE_WIDTH-1:0] rate [NUM_AXES],
  output logic                         calibrated,
  output logic                         calib_done,
  output logic [COUNT_W-1:0]           samples_seen
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUB,
    S_MULA,
    S_EMA,
    S_COMMIT,
    S_REPORT
  } state_t;

  state_t             state;
  logic [1:0]         op_q;
  logic               bias_valid;
  logic [COUNT_W-1:0] counter;
  logic               done_q;

  logic               accept;
  logic               is_sample;
  logic [COUNT_W-1:0] counter_next;
  logic               hit;
  logic               report;

  always_comb begin
    accept       = in_valid && (state == S_IDLE);
    is_sample    = (op_q == OP_SAMPLE);
    counter_next = (counter == COUNT_MAX) ? counter : counter + COUNT_W'(1);
    hit          = !bias_valid && (counter_next >= calib_len);
    report       = (state == S_REPORT) && (!out_valid || !out_stall);
    in_stall     = (state != S_IDLE);

    ctl.load_raw      = accept && (operation == OP_SAMPLE);
    ctl.sub           = (state == S_SUB);
    ctl.mul_new       = (state == S_MULA);
    ctl.ema           = (state == S_EMA);
    ctl.commit_sample = (state == S_COMMIT) && is_sample;
    ctl.clear_filt    = (state == S_COMMIT) &&
                        ((op_q == OP_RESET) || (is_sample && hit));
    ctl.take_bias     = (state == S_COMMIT) && (op_q == OP_UPDATE);
    ctl.mean_bias     = !bias_valid;
    ctl.first         = (counter == '0);
    ctl.bias_on       = bias_valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      op_q       <= OP_SAMPLE;
      bias_valid <= 1'b0;
      counter    <= '0;
      done_q     <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (report) begin
        out_valid    <= 1'b1;
        rate         <= filt;
        calibrated   <= bias_valid;
        calib_done   <= done_q;
        samples_seen <= counter;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            op_q  <= operation;
            state <= (operation == OP_SAMPLE) ? S_SUB : S_COMMIT;
          end
        end
        S_SUB:  state <= S_MULA;
        S_MULA: state <= S_EMA;
        S_EMA:  state <= S_COMMIT;
        S_COMMIT: begin
          done_q <= 1'b0;
          unique case (op_q)
            OP_SAMPLE: begin
              counter <= counter_next;
              if (hit) begin
                bias_valid <= 1'b1;
                done_q     <= 1'b1;
              end
            end
            OP_RESET: begin
              bias_valid <= 1'b0;
              counter    <= '0;
            end
            OP_UPDATE: bias_valid <= 1'b1;
            default: ;
          endcase
          state <= S_REPORT;
        end
        S_REPORT: begin
          if (report) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- tb/sv/gbef_checker.sv -----
// Result checker for the gyro rate filter: predicts every result and compares it.
module gbef_checker import gbef_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_valid,
  input  logic                         cfg_ready,
  input  logic [CFG_IDX_W-1:0]         cfg_index,
  input  logic [CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [1:0]                   operation,
  input  logic signed [RAW_WIDTH-1:0]  raw_x,
  input  logic signed [RAW_WIDTH-1:0]  raw_y,
  input  logic signed [RAW_WIDTH-1:0]  raw_z,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic signed [RATE_WIDTH-1:0] rate_x,
  input  logic signed [RATE_WIDTH-1:0] rate_y,
  input  logic signed [RATE_WIDTH-1:0] rate_z,
  input  logic                         calibrated,
  input  logic                         calib_done,
  input  logic [COUNT_W-1:0]           samples_seen,
  output int                           outstanding,
  output int                           mismatches
);

  typedef struct packed {
    logic signed [RATE_WIDTH-1:0] rate_x;
    logic signed [RATE_WIDTH-1:0] rate_y;
    logic signed [RATE_WIDTH-1:0] rate_z;
    logic                         calibrated;
    logic                         calib_done;
    logic [COUNT_W-1:0]           samples_seen;
  } rate_report_t;

  rate_report_t       pending_reports[$];
  longint             filt_rate [NUM_AXES];
  longint             bias_rate [NUM_AXES];
  logic               calib_flag;
  int unsigned        sample_total;
  logic [ALPHA_W-1:0] alpha_q16;
  logic [GAIN_W-1:0]  gain_q8;
  logic [COUNT_W-1:0] calib_len;

  function automatic longint clamp_rate(input longint v);
    longint hi;
    longint lo;
    hi = (longint'(1) <<< (RATE_WIDTH - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) return hi;
    if (v < lo) return lo;
    return v;
  endfunction

  task automatic report_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input longint got, input longint want);
    if (got != want)
      report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  // Step the filter model by one request and queue the report it produces.
  function automatic void advance_filter(input logic [1:0] op,
                                         input logic signed [RAW_WIDTH-1:0] rx,
                                         input logic signed [RAW_WIDTH-1:0] ry,
                                         input logic signed [RAW_WIDTH-1:0] rz);
    logic signed [RAW_WIDTH-1:0] raw [NUM_AXES];
    longint       scaled;
    longint       weight;
    logic         done;
    int           i;
    rate_report_t rep;
    raw[0] = rx;
    raw[1] = ry;
    raw[2] = rz;
    done   = 1'b0;
    // alpha saturates at one
    weight = (alpha_q16 > ALPHA_ONE) ? longint'(ALPHA_ONE) : longint'(alpha_q16);
    case (op)
      OP_SAMPLE: begin
        for (i = 0; i < NUM_AXES; i++) begin
          scaled = longint'(raw[i]) * longint'(gain_q8);
          if (calib_flag) scaled -= bias_rate[i];
          scaled = clamp_rate(scaled);
          if (sample_total > 0)
            filt_rate[i] = clamp_rate((filt_rate[i] * (longint'(ALPHA_ONE) - weight)
                                       + scaled * weight + 32768) >>> ALPHA_FRAC);
          else
            filt_rate[i] = scaled;
        end
        if (sample_total < COUNT_MAX) sample_total++;
        if (!calib_flag) begin
          for (i = 0; i < NUM_AXES; i++)
            bias_rate[i] = (bias_rate[i] + filt_rate[i]) >>> 1;
          if (sample_total >= calib_len) begin
            calib_flag = 1'b1;
            for (i = 0; i < NUM_AXES; i++) filt_rate[i] = 0;
            done = 1'b1;
          end
        end
      end
      OP_RESET: begin
        calib_flag   = 1'b0;
        sample_total = 0;
        for (i = 0; i < NUM_AXES; i++) filt_rate[i] = 0;
      end
      OP_UPDATE: begin
        for (i = 0; i < NUM_AXES; i++) begin
          bias_rate[i] = filt_rate[i];
          filt_rate[i] = 0;
        end
        calib_flag = 1'b1;
      end
      default: ;
    endcase
    rep.rate_x       = RATE_WIDTH'(filt_rate[0]);
    rep.rate_y       = RATE_WIDTH'(filt_rate[1]);
    rep.rate_z       = RATE_WIDTH'(filt_rate[2]);
    rep.calibrated   = calib_flag;
    rep.calib_done   = done;
    rep.samples_seen = COUNT_W'(sample_total);
    pending_reports.push_back(rep);
  endfunction

  always @(posedge clk) begin
    rate_report_t want;
    if (rst) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        filt_rate[i] = 0;
        bias_rate[i] = 0;
      end
      calib_flag   = 1'b0;
      sample_total = 0;
      alpha_q16    = ALPHA_RESET;
      gain_q8      = GAIN_RESET;
      calib_len    = CALIB_RESET;
      pending_reports.delete();
      mismatches   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ALPHA: alpha_q16 = cfg_wdata[ALPHA_W-1:0];
          CFG_GAIN:  gain_q8   = cfg_wdata[GAIN_W-1:0];
          CFG_CALIB: calib_len = cfg_wdata[COUNT_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (pending_reports.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = pending_reports.pop_front();
          check_field("rate_x", longint'(rate_x), longint'(want.rate_x));
          check_field("rate_y", longint'(rate_y), longint'(want.rate_y));
          check_field("rate_z", longint'(rate_z), longint'(want.rate_z));
          check_field("calibrated", longint'(calibrated), longint'(want.calibrated));
          check_field("calib_done", longint'(calib_done), longint'(want.calib_done));
          check_field("samples_seen", longint'(samples_seen), longint'(want.samples_seen));
        end
      end
      if (in_valid && !in_stall) advance_filter(operation, raw_x, raw_y, raw_z);
    end
    outstanding = pending_reports.size();
  end

endmodule

// ----- tb/sv/gyro_bias_calibrated_ema_filter_unit_tb.sv -----
// Testbench top for the gyro rate filter: stimulus, flow control and verdict.
module gyro_bias_calibrated_ema_filter_unit_tb;
  import gbef_pkg::*;

  localparam int CLK_PERIOD = 12;
  // opcode the block leaves unused; must report state unchanged
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic signed [RAW_WIDTH-1:0] RAW_MAX = {1'b0, {(RAW_WIDTH-1){1'b1}}};
  localparam logic signed [RAW_WIDTH-1:0] RAW_MIN = {1'b1, {(RAW_WIDTH-1){1'b0}}};

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         cfg_valid = 1'b0;
  logic                         cfg_ready;
  logic [CFG_IDX_W-1:0]         cfg_index = '0;
  logic [CFG_DATA_W-1:0]        cfg_wdata = '0;
  logic                         in_valid = 1'b0;
  logic                         in_stall;
  logic [1:0]                   operation = OP_SAMPLE;
  logic signed [RAW_WIDTH-1:0]  raw_x = '0;
  logic signed [RAW_WIDTH-1:0]  raw_y = '0;
  logic signed [RAW_WIDTH-1:0]  raw_z = '0;
  logic                         out_valid;
  logic                         out_stall = 1'b0;
  logic signed [RATE_WIDTH-1:0] rate_x;
  logic signed [RATE_WIDTH-1:0] rate_y;
  logic signed [RATE_WIDTH-1:0] rate_z;
  logic                         calibrated;
  logic                         calib_done;
  logic [COUNT_W-1:0]           samples_seen;

  int outstanding;
  int mismatch_count;

  // percent of cycles each side spends idle / stalled
  int in_idle_pct   = 16;
  int out_stall_pct = 77;
  // set by the stimulus to ask the receiver for one long hold-off
  bit hold_request  = 1'b0;
  // per-axis offset the random samples cluster around, like a real gyro bias
  int axis_offset [NUM_AXES];

  always #(CLK_PERIOD / 2) clk = ~clk;

  gyro_bias_calibrated_ema_filter_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .raw_x        (raw_x),
    .raw_y        (raw_y),
    .raw_z        (raw_z),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rate_x       (rate_x),
    .rate_y       (rate_y),
    .rate_z       (rate_z),
    .calibrated   (calibrated),
    .calib_done   (calib_done),
    .samples_seen (samples_seen)
  );

  gbef_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .operation    (operation),
    .raw_x        (raw_x),
    .raw_y        (raw_y),
    .raw_z        (raw_z),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .rate_x       (rate_x),
    .rate_y       (rate_y),
    .rate_z       (rate_z),
    .calibrated   (calibrated),
    .calib_done   (calib_done),
    .samples_seen (samples_seen),
    .outstanding  (outstanding),
    .mismatches   (mismatch_count)
  );

  // Receiver: random stall each cycle, or a long hold-off on request so the
  // block backs up and stalls its input while the sender keeps offering.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
      end
      out_stall <= ($urandom_range(99) < out_stall_pct);
    end
  end

  // Random raw rate: extremes, full range, near zero, or around the axis offset.
  function automatic logic signed [RAW_WIDTH-1:0] rand_rate(input int axis);
    case ($urandom_range(9))
      0:       return RAW_MIN;
      1:       return RAW_MAX;
      2:       return RAW_WIDTH'($urandom);
      3:       return RAW_WIDTH'(int'($urandom_range(64)) - 32);
      default: return RAW_WIDTH'(axis_offset[axis] + int'($urandom_range(40)) - 20);
    endcase
  endfunction

  // One request: optional idle gap, then hold it until the block takes it.
  task automatic offer(input logic [1:0] op, input logic signed [RAW_WIDTH-1:0] x,
                       input logic signed [RAW_WIDTH-1:0] y,
                       input logic signed [RAW_WIDTH-1:0] z);
    int gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    operation <= op;
    raw_x     <= x;
    raw_y     <= y;
    raw_z     <= z;
    do @(posedge clk); while (in_stall);
  endtask

  // Stop sending and wait for every outstanding result, then let the
  // pipeline run empty.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // Program a setting, then a stretch of random requests. Mostly samples,
  // with enough reset/update commands to restart calibration often, and an occasional unused opcode.
  task automatic random_phase(input logic [ALPHA_W-1:0] alpha, input logic [GAIN_W-1:0] gain,
                              input logic [COUNT_W-1:0] calib, input int count);
    int         k;
    int         a;
    int         r;
    logic [1:0] op;
    settle();
    cfg_write(CFG_ALPHA, CFG_DATA_W'(alpha));
    cfg_write(CFG_GAIN, CFG_DATA_W'(gain));
    cfg_write(CFG_CALIB, CFG_DATA_W'(calib));
    for (a = 0; a < NUM_AXES; a++) axis_offset[a] = int'($urandom_range(4000)) - 2000;
    for (k = 0; k < count; k++) begin
      if (k == count / 4) hold_request = 1'b1;
      // sender pause mid-phase until the block has drained completely
      if (k == count / 2) settle();
      r = $urandom_range(99);
      if (r < 84)      op = OP_SAMPLE;
      else if (r < 91) op = OP_RESET;
      else if (r < 97) op = OP_UPDATE;
      else             op = OP_UNUSED;
      offer(op, rand_rate(0), rand_rate(1), rand_rate(2));
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: default settings, calibration length 40.
    offer(OP_SAMPLE, RAW_MAX, RAW_MIN, '0);            // first sample loads directly
    offer(OP_SAMPLE, RAW_MIN, RAW_MAX, -16'sd1);
    offer(OP_SAMPLE, '0, '0, '0);
    offer(OP_UNUSED, 16'sd1, 16'sd2, 16'sd3);          // state must not move
    offer(OP_UPDATE, '0, '0, '0);                       // filter becomes bias
    offer(OP_SAMPLE, RAW_MAX, RAW_MAX, RAW_MAX);        // bias now subtracted
    offer(OP_SAMPLE, RAW_MIN, RAW_MIN, RAW_MIN);
    offer(OP_RESET, '0, '0, '0);                        // bias kept, rest cleared
    offer(OP_SAMPLE, 16'sd100, -16'sd100, 16'sd5);

    // zero calibration length, full gain, alpha above one
    settle();
    cfg_write(CFG_CALIB, '0);
    cfg_write(CFG_GAIN, CFG_DATA_W'(16'hFFFF));
    cfg_write(CFG_ALPHA, '1);
    offer(OP_SAMPLE, RAW_MIN, RAW_MAX, 16'sd12345);     // calibrates at once
    offer(OP_SAMPLE, RAW_MAX, RAW_MIN, RAW_MIN);        // bias pushes past full scale
    offer(OP_SAMPLE, '0, '0, '0);
    offer(OP_RESET, '0, '0, '0);
    offer(OP_UPDATE, '0, '0, '0);                       // update from a cleared filter

    // alpha zero freezes the filter; short calibration
    settle();
    cfg_write(CFG_ALPHA, '0);
    cfg_write(CFG_GAIN, CFG_DATA_W'(16'd1));
    cfg_write(CFG_CALIB, CFG_DATA_W'(16'd2));
    offer(OP_RESET, '0, '0, '0);
    offer(OP_SAMPLE, 16'sd5, -16'sd5, 16'sd7);
    offer(OP_SAMPLE, -16'sd9, 16'sd9, 16'sd1);          // completes calibration
    offer(OP_SAMPLE, 16'sd1, 16'sd1, 16'sd1);
    offer(OP_UNUSED, RAW_MAX, RAW_MIN, RAW_MAX);

    // Random: sender 16% idle / receiver 77% stalled, then swapped, then none.
    in_idle_pct   = 16;
    out_stall_pct = 77;
    random_phase(ALPHA_RESET, GAIN_RESET, 16'd8, 175);
    random_phase(ALPHA_ONE, 16'hFFFF, 16'd1, 175);
    in_idle_pct   = 77;
    out_stall_pct = 16;
    random_phase('1, 16'd1, 16'd0, 175);
    random_phase(17'd1, 16'd0, 16'd5, 175);
    in_idle_pct   = 0;
    out_stall_pct = 0;
    random_phase(ALPHA_W'($urandom_range(131071)), GAIN_W'($urandom), CALIB_RESET, 175);
    random_phase(17'd32768, 16'd256, 16'd2, 175);

    settle();
    if (mismatch_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

  // Watchdog: well beyond the slowest legal run, long receiver hold-offs included.
  initial begin
    #(CLK_PERIOD * 200000);
    $display("simulation failed");
    $finish;
  end

endmodule
